[sv/tcsgr_pkg.sv]
// Shared types, constants and helper functions of the cell to SGR encoder.
`timescale 1ns / 1ps

package tcsgr_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int QUEUE_DEPTH  = 4;
    localparam int SEG_CNT      = 21;
    localparam int STR_LEN      = 17;

    localparam logic [10:0] JUMP_MAX   = 11'd2047;
    localparam logic [31:0] HAS_EXT    = 32'h1000_0000;
    localparam logic [31:0] UL_STYLE   = 32'h1C00_0000;
    localparam logic [31:0] COLOR_BITS = 32'h03FF_FFFF;
    localparam logic [15:0] SURR_HI    = 16'hD800;
    localparam logic [15:0] SURR_LO    = 16'hDC00;

    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_LINK = 2'd1;
    localparam logic [1:0] KIND_COMB = 2'd2;

    // Segment codes, in stream order.
    localparam logic [4:0] SEG_JX_E    = 5'd0;
    localparam logic [4:0] SEG_JC_E    = 5'd1;
    localparam logic [4:0] SEG_SGR_PRE = 5'd2;
    localparam logic [4:0] SEG_SGR_RST = 5'd3;
    localparam logic [4:0] SEG_INV     = 5'd4;
    localparam logic [4:0] SEG_BOLD    = 5'd5;
    localparam logic [4:0] SEG_BLINK   = 5'd6;
    localparam logic [4:0] SEG_INVIS   = 5'd7;
    localparam logic [4:0] SEG_STRIKE  = 5'd8;
    localparam logic [4:0] SEG_FGCOL   = 5'd9;
    localparam logic [4:0] SEG_ITAL    = 5'd10;
    localparam logic [4:0] SEG_DIM     = 5'd11;
    localparam logic [4:0] SEG_BGCOL   = 5'd12;
    localparam logic [4:0] SEG_ULSTY   = 5'd13;
    localparam logic [4:0] SEG_ULCOL   = 5'd14;
    localparam logic [4:0] SEG_LCLOSE  = 5'd15;
    localparam logic [4:0] SEG_LMARK   = 5'd16;
    localparam logic [4:0] SEG_JX_L    = 5'd17;
    localparam logic [4:0] SEG_JC_L    = 5'd18;
    localparam logic [4:0] SEG_CONTENT = 5'd19;
    localparam logic [4:0] SEG_JX_END  = 5'd20;

    localparam logic [SEG_CNT-1:0] ITEM_MASK = 21'h007FF8;

    localparam logic [15:0] CH_ESC   = 16'h001B;
    localparam logic [15:0] CH_LBR   = 16'h005B;
    localparam logic [15:0] CH_RBR   = 16'h005D;
    localparam logic [15:0] CH_SEMI  = 16'h003B;
    localparam logic [15:0] CH_COLON = 16'h003A;
    localparam logic [15:0] CH_BEL   = 16'h0007;
    localparam logic [15:0] CH_0     = 16'h0030;
    localparam logic [15:0] CH_M     = 16'h006D;
    localparam logic [15:0] CH_X     = 16'h0058;
    localparam logic [15:0] CH_C     = 16'h0043;

    typedef struct packed {
        logic [SEG_CNT-1:0] segs;
        logic [31:0]        fg;
        logic [31:0]        bg;
        logic [31:0]        ul;
        logic [15:0]        jump_bcd;
        logic [15:0]        jend_bcd;
        logic [31:0]        link;
        logic [9:0]         column;
        logic [15:0]        u0;
        logic [15:0]        u1;
        logic               two;
        logic               comb;
    } t_desc;

    function automatic logic [15:0] bcd_inc(logic [15:0] b);
        logic [15:0] r;
        logic        c;
        r = b;
        c = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (c) begin
                if (r[i*4 +: 4] == 4'd9) begin
                    r[i*4 +: 4] = 4'd0;
                end else begin
                    r[i*4 +: 4] = r[i*4 +: 4] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Three decimal digits of a byte by reciprocal multiplication.
    function automatic logic [11:0] bcd8(logic [7:0] n);
        logic [15:0] p;
        logic [15:0] q;
        logic [3:0]  h;
        logic [3:0]  t;
        logic [3:0]  o;
        logic [7:0]  rem;
        p   = 16'(n) * 16'd41;
        h   = 4'(p >> 12);
        rem = n - 8'({4'd0, h} * 8'd100);
        q   = 16'(rem) * 16'd205;
        t   = 4'(q >> 11);
        o   = 4'(rem - 8'({4'd0, t} * 8'd10));
        return {h, t, o};
    endfunction

endpackage

[sv/tcsgr_if.sv]
// Request and result channel interfaces of the cell to SGR encoder.
`timescale 1ns / 1ps

interface tcsgr_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] content;
    logic [31:0] fg_attr;
    logic [31:0] bg_attr;
    logic [31:0] ul_ext;
    logic [31:0] link_id;
    logic        first_cell;
    logic        last_cell;

    modport source(output valid, req_type, content, fg_attr, bg_attr, ul_ext, link_id,
                   first_cell, last_cell, input ready);
    modport sink(input valid, req_type, content, fg_attr, bg_attr, ul_ext, link_id,
                 first_cell, last_cell, output ready);
endinterface

interface tcsgr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic [15:0] unit2;
    logic [15:0] unit3;
    logic [2:0]  unit_count;
    logic [31:0] marker_link;
    logic [9:0]  marker_column;
    logic        run_end;

    modport source(output valid, kind, unit0, unit1, unit2, unit3, unit_count,
                   marker_link, marker_column, run_end, input ready);
    modport sink(input valid, kind, unit0, unit1, unit2, unit3, unit_count,
                 marker_link, marker_column, run_end, output ready);
endinterface

[sv/tcsgr_front.sv]
// Front end: takes requests, keeps the attribute state and classifies each cell.
`timescale 1ns / 1ps

module tcsgr_front #(
    parameter int MAX_COLS = tcsgr_pkg::MAX_COLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcsgr_in_if.sink           i_cell,
    input  logic               i_q_full,
    output logic               o_push,
    output tcsgr_pkg::t_desc   o_desc
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CX_W  = (COL_W > 10) ? COL_W : 10;

    logic [31:0]      r_last_fg, n_last_fg;
    logic [31:0]      r_last_bg, n_last_bg;
    logic [31:0]      r_last_ul, n_last_ul;
    logic [31:0]      r_last_link, n_last_link;
    logic [31:0]      r_lsb, n_lsb;
    logic [10:0]      r_jump, n_jump;
    logic [15:0]      r_jump_bcd, n_jump_bcd;
    logic [1:0]       r_skip, n_skip;
    logic [COL_W-1:0] r_col, n_col;

    logic [31:0]      lsb0;
    logic [10:0]      jc0;
    logic [15:0]      jb0;
    logic [10:0]      jc1;
    logic [15:0]      jb1;
    logic [1:0]       skip0;
    logic [COL_W-1:0] col0;
    logic [CX_W-1:0]  colx;
    logic [31:0]      bg;
    logic [31:0]      dfg;
    logic [31:0]      dbg;
    logic [31:0]      dul;
    logic             chg;
    logic             cnz;
    logic             rst_sgr;
    logic [20:0]      cp;
    logic [20:0]      cps;
    logic             accept;
    tcsgr_pkg::t_desc desc;

    assign i_cell.ready = !i_q_full;
    assign accept       = i_cell.valid && !i_q_full;

    always_comb begin
        lsb0  = i_cell.first_cell ? r_last_bg : r_lsb;
        jc0   = i_cell.first_cell ? 11'd0 : r_jump;
        jb0   = i_cell.first_cell ? 16'd0 : r_jump_bcd;
        skip0 = i_cell.first_cell ? 2'd0 : r_skip;
        col0  = i_cell.first_cell ? '0 : r_col;
        colx  = CX_W'(col0);
        bg    = i_cell.bg_attr & ~tcsgr_pkg::HAS_EXT;
        dfg   = i_cell.fg_attr ^ r_last_fg;
        dbg   = i_cell.bg_attr ^ r_last_bg;
        dul   = i_cell.ul_ext ^ r_last_ul;
        chg   = (i_cell.fg_attr != r_last_fg) || (bg != r_last_bg) ||
                (i_cell.ul_ext != r_last_ul);
        cnz   = i_cell.content[21:0] != 22'd0;
        rst_sgr = (i_cell.fg_attr == 32'd0) && (i_cell.bg_attr == 32'd0);
        cp    = i_cell.content[20:0];
        cps   = cp - 21'h010000;
        // An attribute change flushes the pending jump before the run count moves on.
        jc1   = chg ? 11'd0 : jc0;
        jb1   = chg ? 16'd0 : jb0;

        n_last_fg   = r_last_fg;
        n_last_bg   = r_last_bg;
        n_last_ul   = r_last_ul;
        n_last_link = r_last_link;
        n_jump      = jc0;
        n_jump_bcd  = jb0;
        n_skip      = skip0;
        n_col       = col0;
        n_lsb       = lsb0;

        desc          = '0;
        desc.fg       = i_cell.fg_attr;
        desc.bg       = i_cell.bg_attr;
        desc.ul       = i_cell.ul_ext;
        desc.jump_bcd = jb0;
        desc.link     = i_cell.link_id;
        desc.column   = colx[9:0];
        desc.comb     = i_cell.content[21];
        if (cp > 21'h00FFFF) begin
            desc.u0  = 16'(cps >> 10) + tcsgr_pkg::SURR_HI;
            desc.u1  = {6'd0, cps[9:0]} + tcsgr_pkg::SURR_LO;
            desc.two = 1'b1;
        end else begin
            desc.u0  = cp[15:0];
            desc.two = 1'b0;
        end

        if (i_cell.req_type) begin
            n_last_fg   = i_cell.fg_attr;
            n_last_bg   = i_cell.bg_attr;
            n_last_ul   = i_cell.ul_ext;
            n_last_link = i_cell.link_id;
            n_lsb       = i_cell.bg_attr;
            n_jump      = 11'd0;
            n_jump_bcd  = 16'd0;
            n_skip      = 2'd0;
            n_col       = '0;
        end else begin
            if (skip0 != 2'd0) begin
                n_skip = skip0 - 2'd1;
            end else begin
                // The pending jump goes out before the SGR if there is one,
                // otherwise just before the cell content.
                if ((jc0 != 11'd0) && (chg || cnz)) begin
                    if (chg) begin
                        desc.segs[tcsgr_pkg::SEG_JX_E] = r_last_bg != lsb0;
                        desc.segs[tcsgr_pkg::SEG_JC_E] = 1'b1;
                    end else begin
                        desc.segs[tcsgr_pkg::SEG_JX_L] = r_last_bg != lsb0;
                        desc.segs[tcsgr_pkg::SEG_JC_L] = 1'b1;
                    end
                end
                if (chg) begin
                    if (rst_sgr) begin
                        desc.segs[tcsgr_pkg::SEG_SGR_PRE] = 1'b1;
                        desc.segs[tcsgr_pkg::SEG_SGR_RST] = 1'b1;
                    end else begin
                        desc.segs[tcsgr_pkg::SEG_INV]    = dfg[26];
                        desc.segs[tcsgr_pkg::SEG_BOLD]   = dfg[27];
                        desc.segs[tcsgr_pkg::SEG_BLINK]  = dfg[29];
                        desc.segs[tcsgr_pkg::SEG_INVIS]  = dfg[30];
                        desc.segs[tcsgr_pkg::SEG_STRIKE] = dfg[31];
                        desc.segs[tcsgr_pkg::SEG_FGCOL]  =
                            (dfg & tcsgr_pkg::COLOR_BITS) != 32'd0;
                        desc.segs[tcsgr_pkg::SEG_ITAL]   = dbg[26];
                        desc.segs[tcsgr_pkg::SEG_DIM]    = dbg[27];
                        desc.segs[tcsgr_pkg::SEG_BGCOL]  =
                            (dbg & tcsgr_pkg::COLOR_BITS) != 32'd0;
                        desc.segs[tcsgr_pkg::SEG_ULSTY]  = i_cell.bg_attr[28] &&
                            ((dul & tcsgr_pkg::UL_STYLE) != 32'd0);
                        desc.segs[tcsgr_pkg::SEG_ULCOL]  = i_cell.bg_attr[28] &&
                            ((dul & tcsgr_pkg::COLOR_BITS) != 32'd0);
                        desc.segs[tcsgr_pkg::SEG_SGR_PRE] =
                            (desc.segs & tcsgr_pkg::ITEM_MASK) != '0;
                    end
                    n_last_fg = i_cell.fg_attr;
                    n_last_bg = bg;
                    n_last_ul = i_cell.ul_ext;
                end
                if (i_cell.link_id != r_last_link) begin
                    desc.segs[tcsgr_pkg::SEG_LCLOSE] = r_last_link != 32'd0;
                    if (i_cell.bg_attr[28] && (i_cell.link_id != 32'd0)) begin
                        desc.segs[tcsgr_pkg::SEG_LMARK] = 1'b1;
                        n_last_link = i_cell.link_id;
                    end else begin
                        n_last_link = 32'd0;
                    end
                end
                if (cnz) begin
                    desc.segs[tcsgr_pkg::SEG_CONTENT] = 1'b1;
                    n_jump     = 11'd0;
                    n_jump_bcd = 16'd0;
                end else if (jc1 < tcsgr_pkg::JUMP_MAX) begin
                    n_jump     = jc1 + 11'd1;
                    n_jump_bcd = tcsgr_pkg::bcd_inc(jb1);
                end
                n_skip = (i_cell.content[23:22] > 2'd1) ? i_cell.content[23:22] - 2'd1 : 2'd0;
            end
            desc.jend_bcd = n_jump_bcd;
            if (i_cell.last_cell) begin
                desc.segs[tcsgr_pkg::SEG_JX_END] = (n_jump != 11'd0) && (n_last_bg != lsb0);
                n_lsb      = n_last_bg;
                n_jump     = 11'd0;
                n_jump_bcd = 16'd0;
                n_skip     = 2'd0;
                n_col      = '0;
            end else if (col0 < COL_W'(MAX_COLS - 1)) begin
                n_col = col0 + 1'b1;
            end
        end
    end

    assign o_push = accept && !i_cell.req_type && (desc.segs != '0);
    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_fg   <= '0;
            r_last_bg   <= '0;
            r_last_ul   <= '0;
            r_last_link <= '0;
            r_lsb       <= '0;
            r_jump      <= '0;
            r_jump_bcd  <= '0;
            r_skip      <= '0;
            r_col       <= '0;
        end else if (accept) begin
            r_last_fg   <= n_last_fg;
            r_last_bg   <= n_last_bg;
            r_last_ul   <= n_last_ul;
            r_last_link <= n_last_link;
            r_lsb       <= n_lsb;
            r_jump      <= n_jump;
            r_jump_bcd  <= n_jump_bcd;
            r_skip      <= n_skip;
            r_col       <= n_col;
        end
    end

endmodule

[sv/tcsgr_queue.sv]
// Short queue of classified cells between the front and back ends.
`timescale 1ns / 1ps

module tcsgr_queue #(
    parameter int DEPTH = tcsgr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcsgr_pkg::t_desc i_desc,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output tcsgr_pkg::t_desc o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcsgr_pkg::t_desc r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

[sv/tcsgr_back.sv]
// Back end: walks the segments of a cell, packs code units and drives the results.
`timescale 1ns / 1ps

module tcsgr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  tcsgr_pkg::t_desc i_head,
    output logic             o_pop,
    tcsgr_out_if.source      o_res
);

    typedef struct packed {
        logic [tcsgr_pkg::STR_LEN-1:0][15:0] ch;
        logic [4:0]                          len;
    } t_str;

    function automatic t_str sput(t_str s, logic [15:0] c);
        t_str r;
        r = s;
        if (r.len < 5'(tcsgr_pkg::STR_LEN)) begin
            r.ch[r.len] = c;
            r.len       = r.len + 5'd1;
        end
        return r;
    endfunction

    function automatic logic [15:0] dch(logic [3:0] d);
        return tcsgr_pkg::CH_0 + {12'd0, d};
    endfunction

    // Decimal digits without leading zeros, at least one.
    function automatic t_str sdig(t_str s, logic [15:0] b);
        t_str r;
        logic started;
        r = s;
        started = 1'b0;
        for (int i = 3; i > 0; i--) begin
            if ((b[i*4 +: 4] != 4'd0) || started) begin
                r = sput(r, dch(b[i*4 +: 4]));
                started = 1'b1;
            end
        end
        r = sput(r, dch(b[3:0]));
        return r;
    endfunction

    function automatic t_str sbyte(t_str s, logic [7:0] v);
        return sdig(s, {4'd0, tcsgr_pkg::bcd8(v)});
    endfunction

    function automatic t_str sflag(t_str s, logic v, logic [3:0] on, logic [3:0] off);
        t_str r;
        r = s;
        if (v) begin
            r = sput(r, dch(on));
        end else begin
            r = sput(r, dch(4'd2));
            r = sput(r, dch(off));
        end
        r = sput(r, tcsgr_pkg::CH_SEMI);
        return r;
    endfunction

    function automatic t_str scolour(logic [31:0] v, logic [3:0] c);
        t_str r;
        r = '0;
        case (v[25:24])
            2'd0: begin
                r = sput(r, dch(c));
                r = sput(r, dch(4'd9));
            end
            2'd1: begin
                if (c == 4'd5) begin
                    r = sput(r, dch(4'd5));
                    r = sput(r, dch(4'd8));
                    r = sput(r, tcsgr_pkg::CH_SEMI);
                    r = sput(r, dch(4'd5));
                    r = sput(r, tcsgr_pkg::CH_SEMI);
                    r = sbyte(r, {4'd0, v[3:0]});
                end else if (v[3]) begin
                    if (c == 4'd3) begin
                        r = sput(r, dch(4'd9));
                    end else begin
                        r = sput(r, dch(4'd1));
                        r = sput(r, dch(4'd0));
                    end
                    r = sput(r, dch({1'b0, v[2:0]}));
                end else begin
                    r = sput(r, dch(c));
                    r = sput(r, dch({1'b0, v[2:0]}));
                end
            end
            2'd2: begin
                r = sput(r, dch(c));
                r = sput(r, dch(4'd8));
                r = sput(r, tcsgr_pkg::CH_SEMI);
                r = sput(r, dch(4'd5));
                r = sput(r, tcsgr_pkg::CH_SEMI);
                r = sbyte(r, v[7:0]);
            end
            default: begin
                r = sput(r, dch(c));
                r = sput(r, dch(4'd8));
                r = sput(r, tcsgr_pkg::CH_SEMI);
                r = sput(r, dch(4'd2));
                r = sput(r, tcsgr_pkg::CH_SEMI);
                r = sbyte(r, v[23:16]);
                r = sput(r, tcsgr_pkg::CH_SEMI);
                r = sbyte(r, v[15:8]);
                r = sput(r, tcsgr_pkg::CH_SEMI);
                r = sbyte(r, v[7:0]);
            end
        endcase
        r = sput(r, tcsgr_pkg::CH_SEMI);
        return r;
    endfunction

    function automatic t_str scsi(logic [15:0] b, logic [15:0] fin);
        t_str r;
        r = '0;
        r = sput(r, tcsgr_pkg::CH_ESC);
        r = sput(r, tcsgr_pkg::CH_LBR);
        r = sdig(r, b);
        r = sput(r, fin);
        return r;
    endfunction

    function automatic t_str seg_str(logic [4:0] seg, tcsgr_pkg::t_desc d);
        t_str r;
        r = '0;
        case (seg)
            tcsgr_pkg::SEG_JX_E, tcsgr_pkg::SEG_JX_L: r = scsi(d.jump_bcd, tcsgr_pkg::CH_X);
            tcsgr_pkg::SEG_JC_E, tcsgr_pkg::SEG_JC_L: r = scsi(d.jump_bcd, tcsgr_pkg::CH_C);
            tcsgr_pkg::SEG_JX_END: r = scsi(d.jend_bcd, tcsgr_pkg::CH_X);
            tcsgr_pkg::SEG_SGR_PRE: begin
                r = sput(r, tcsgr_pkg::CH_ESC);
                r = sput(r, tcsgr_pkg::CH_LBR);
            end
            tcsgr_pkg::SEG_SGR_RST: r = sput(r, tcsgr_pkg::CH_SEMI);
            tcsgr_pkg::SEG_INV:     r = sflag(r, d.fg[26], 4'd7, 4'd7);
            tcsgr_pkg::SEG_BOLD:    r = sflag(r, d.fg[27], 4'd1, 4'd2);
            tcsgr_pkg::SEG_BLINK:   r = sflag(r, d.fg[29], 4'd5, 4'd5);
            tcsgr_pkg::SEG_INVIS:   r = sflag(r, d.fg[30], 4'd8, 4'd8);
            tcsgr_pkg::SEG_STRIKE:  r = sflag(r, d.fg[31], 4'd9, 4'd9);
            tcsgr_pkg::SEG_FGCOL:   r = scolour(d.fg, 4'd3);
            tcsgr_pkg::SEG_ITAL:    r = sflag(r, d.bg[26], 4'd3, 4'd3);
            tcsgr_pkg::SEG_DIM:     r = sflag(r, d.bg[27], 4'd2, 4'd2);
            tcsgr_pkg::SEG_BGCOL:   r = scolour(d.bg, 4'd4);
            tcsgr_pkg::SEG_ULSTY: begin
                r = sput(r, dch(4'd4));
                r = sput(r, tcsgr_pkg::CH_COLON);
                r = sput(r, dch({1'b0, d.ul[28:26]}));
                r = sput(r, tcsgr_pkg::CH_SEMI);
            end
            tcsgr_pkg::SEG_ULCOL:   r = scolour(d.ul, 4'd5);
            tcsgr_pkg::SEG_LCLOSE: begin
                r = sput(r, tcsgr_pkg::CH_ESC);
                r = sput(r, tcsgr_pkg::CH_RBR);
                r = sput(r, dch(4'd8));
                r = sput(r, tcsgr_pkg::CH_SEMI);
                r = sput(r, tcsgr_pkg::CH_SEMI);
                r = sput(r, tcsgr_pkg::CH_BEL);
            end
            tcsgr_pkg::SEG_CONTENT: begin
                r = sput(r, d.u0);
                if (d.two) begin
                    r = sput(r, d.u1);
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    tcsgr_pkg::t_desc                  r_desc;
    logic [tcsgr_pkg::SEG_CNT-1:0]     r_rem, n_rem;
    logic [4:0]                        r_idx, n_idx;
    logic                              r_busy;
    logic [3:0][15:0]                  r_pack, n_pack;
    logic [1:0]                        r_pack_n, n_pack_n;

    logic        r_ov;
    logic [1:0]  r_kind;
    logic [3:0][15:0] r_units;
    logic [2:0]  r_cnt;
    logic [31:0] r_link;
    logic [9:0]  r_col;
    logic        r_end;

    logic [4:0]                    seg;
    logic [tcsgr_pkg::SEG_CNT-1:0] rest;
    logic                          last_seg;
    t_str                          str;
    logic                          is_marker;
    logic                          item_last;
    logic                          last_char;
    logic                          final_unit;
    logic                          need;
    logic [15:0]                   ch;
    logic                          out_free;
    logic                          emit;
    logic                          finish;
    logic [1:0]                    e_kind;
    logic [3:0][15:0]              e_pk;
    logic [3:0][15:0]              e_units;
    logic [2:0]                    e_cnt;
    logic [31:0]                   e_link;
    logic [9:0]                    e_col;
    logic                          e_end;

    always_comb begin
        seg = 5'd0;
        for (int i = tcsgr_pkg::SEG_CNT - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                seg = 5'(i);
            end
        end
        rest      = r_rem & ~(tcsgr_pkg::SEG_CNT'(1) << seg);
        last_seg  = rest == '0;
        str       = seg_str(seg, r_desc);
        is_marker = (seg == tcsgr_pkg::SEG_LMARK) ||
                    ((seg == tcsgr_pkg::SEG_CONTENT) && r_desc.comb);
        item_last = (seg >= tcsgr_pkg::SEG_SGR_RST) && (seg <= tcsgr_pkg::SEG_ULCOL) &&
                    ((rest & tcsgr_pkg::ITEM_MASK) == '0);
        last_char = r_idx == (str.len - 5'd1);
        ch        = str.ch[r_idx];
        // The last SGR parameter ends in the final byte instead of a separator.
        if (item_last && last_char) begin
            ch = tcsgr_pkg::CH_M;
        end
        final_unit = last_char && last_seg;
        need       = (r_pack_n == 2'd3) || final_unit;
        out_free   = !r_ov || o_res.ready;

        n_rem    = r_rem;
        n_idx    = r_idx;
        n_pack   = r_pack;
        n_pack_n = r_pack_n;
        emit     = 1'b0;
        finish   = 1'b0;
        e_kind   = tcsgr_pkg::KIND_TEXT;
        e_pk     = r_pack;
        e_cnt    = {1'b0, r_pack_n};
        e_link   = 32'd0;
        e_col    = 10'd0;
        e_end    = 1'b0;

        if (r_busy) begin
            if (is_marker) begin
                if (r_pack_n != 2'd0) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        n_pack_n = 2'd0;
                    end
                end else if (out_free) begin
                    emit  = 1'b1;
                    e_cnt = 3'd0;
                    e_end = last_seg;
                    if (seg == tcsgr_pkg::SEG_LMARK) begin
                        e_kind = tcsgr_pkg::KIND_LINK;
                        e_link = r_desc.link;
                    end else begin
                        e_kind = tcsgr_pkg::KIND_COMB;
                        e_col  = r_desc.column;
                    end
                    n_rem  = rest;
                    finish = last_seg;
                end
            end else if (!need || out_free) begin
                e_pk[r_pack_n] = ch;
                n_pack         = e_pk;
                if (need) begin
                    emit     = 1'b1;
                    e_cnt    = {1'b0, r_pack_n} + 3'd1;
                    e_end    = final_unit;
                    n_pack_n = 2'd0;
                end else begin
                    n_pack_n = r_pack_n + 2'd1;
                end
                if (last_char) begin
                    n_idx  = 5'd0;
                    n_rem  = rest;
                    finish = last_seg;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
        end

        for (int j = 0; j < 4; j++) begin
            e_units[j] = (3'(j) < e_cnt) ? e_pk[j] : 16'd0;
        end
    end

    assign o_pop = !i_empty && (!r_busy || finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rem    <= '0;
            r_idx    <= '0;
            r_pack_n <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_pack_n <= n_pack_n;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_rem  <= i_head.segs;
                r_idx  <= 5'd0;
            end else begin
                if (finish) begin
                    r_busy <= 1'b0;
                end
                r_rem <= n_rem;
                r_idx <= n_idx;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pack <= n_pack;
        if (o_pop) begin
            r_desc <= i_head;
        end
        if (emit) begin
            r_kind  <= e_kind;
            r_units <= e_units;
            r_cnt   <= e_cnt;
            r_link  <= e_link;
            r_col   <= e_col;
            r_end   <= e_end;
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.kind          = r_kind;
    assign o_res.unit0         = r_units[0];
    assign o_res.unit1         = r_units[1];
    assign o_res.unit2         = r_units[2];
    assign o_res.unit3         = r_units[3];
    assign o_res.unit_count    = r_cnt;
    assign o_res.marker_link   = r_link;
    assign o_res.marker_column = r_col;
    assign o_res.run_end       = r_end;

endmodule

[sv/terminal_cell_to_ansi_sgr_encoder.sv]
// Top level of the terminal cell to ANSI SGR encoder.
// Throughput: the front takes one request a cycle while the queue has room; the back
// produces one code unit a cycle while its result register is not stalled; a link or
// combined marker goes out as a result of its own, after any code units that wait
// ahead of it have gone out.
// Reset clears the attribute state, the queue pointers and the result valid flag.
`timescale 1ns / 1ps

module terminal_cell_to_ansi_sgr_encoder #(
    parameter int MAX_COLS = tcsgr_pkg::MAX_COLS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcsgr_in_if.sink     i_cell,
    tcsgr_out_if.source  o_res
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    tcsgr_pkg::t_desc push_desc;
    tcsgr_pkg::t_desc head_desc;

    tcsgr_front #(
        .MAX_COLS(MAX_COLS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (i_cell),
        .i_q_full (q_full),
        .o_push   (push),
        .o_desc   (push_desc)
    );

    tcsgr_queue #(
        .DEPTH(tcsgr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_desc)
    );

    tcsgr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_desc),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

[sv/tcsgr_checker.sv]
// Port level checks of the result stream, bound to the encoder top level.
`timescale 1ns / 1ps

module tcsgr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [15:0] i_unit3,
    input logic [2:0]  i_unit_count,
    input logic [31:0] i_marker_link,
    input logic [9:0]  i_marker_column,
    input logic        i_run_end
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_unit_count) && $stable(i_run_end))
        else $error("result request changed while stalled");

    a_text_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == tcsgr_pkg::KIND_TEXT) |->
            (i_unit_count != 3'd0) && (i_unit_count <= 3'd4))
        else $error("text result with bad unit count");

    a_marker_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind != tcsgr_pkg::KIND_TEXT) |-> (i_unit_count == 3'd0))
        else $error("marker result carries code units");

    a_text_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == tcsgr_pkg::KIND_TEXT) |->
            (i_marker_link == 32'd0) && (i_marker_column == 10'd0))
        else $error("text result carries marker fields");

    a_unused_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_unit_count < 3'd4) |-> (i_unit3 == 16'd0))
        else $error("unused code unit not zero");

endmodule

bind terminal_cell_to_ansi_sgr_encoder tcsgr_checker u_tcsgr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_kind          (o_res.kind),
    .i_unit3         (o_res.unit3),
    .i_unit_count    (o_res.unit_count),
    .i_marker_link   (o_res.marker_link),
    .i_marker_column (o_res.marker_column),
    .i_run_end       (o_res.run_end)
);

[tb/tb_terminal_cell_to_ansi_sgr_encoder.sv]
// Self-checking testbench of the cell to SGR encoder: directed table, random lines, then a long empty run.
`timescale 1ns / 1ps

module tb_terminal_cell_to_ansi_sgr_encoder;

    localparam int  COL_LAST    = tcsgr_pkg::MAX_COLS_DEF - 1;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  RAND_ITEMS  = 350;
    localparam bit  REQ_CELL    = 1'b0;
    localparam bit  REQ_LOAD    = 1'b1;

    typedef struct {
        bit          req_type;
        logic [23:0] content;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [31:0] ul;
        logic [31:0] link;
        bit          first;
        bit          last;
    } t_cell;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] u0;
        logic [15:0] u1;
        logic [15:0] u2;
        logic [15:0] u3;
        logic [2:0]  cnt;
        logic [31:0] link;
        logic [9:0]  col;
        logic        run_end;
    } t_res;

    typedef struct {
        t_cell c;
        bit    typed;
        t_res  r;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tcsgr_in_if  cell_if ();
    tcsgr_out_if res_if ();

    terminal_cell_to_ansi_sgr_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_if),
        .o_res   (res_if)
    );

    // Encoder state as the testbench tracks it.
    logic [31:0] st_fg, st_bg, st_ul, st_link, st_line_bg;
    int          st_jump, st_skip, st_col;

    logic [15:0] unit_buf[4];
    int          unit_n;
    logic [15:0] seq_buf[128];
    int          seq_n;
    t_res        step_res[$];
    t_res        sgr_expected[$];

    int errors;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_go;
    int hold_cnt;
    int cycles;

    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
        $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, got_v, $realtime);
        errors++;
    endtask

    function logic [15:0] dch(input int n);
        return tcsgr_pkg::CH_0 + 16'(n);
    endfunction

    task put_res(input logic [1:0] kind, input int cnt, input logic [31:0] lnk, input int col);
        t_res r;
        r.kind    = kind;
        r.u0      = (cnt > 0) ? unit_buf[0] : 16'h0;
        r.u1      = (cnt > 1) ? unit_buf[1] : 16'h0;
        r.u2      = (cnt > 2) ? unit_buf[2] : 16'h0;
        r.u3      = (cnt > 3) ? unit_buf[3] : 16'h0;
        r.cnt     = 3'(cnt);
        r.link    = lnk;
        r.col     = 10'(col);
        r.run_end = 1'b0;
        if (step_res.size() < 40) step_res.push_back(r);
    endtask

    task flush_units();
        if (unit_n != 0) put_res(tcsgr_pkg::KIND_TEXT, unit_n, 32'h0, 0);
        unit_n = 0;
    endtask

    task emit(input logic [15:0] u);
        unit_buf[unit_n] = u;
        unit_n++;
        if (unit_n == 4) flush_units();
    endtask

    task seq(input logic [15:0] u);
        if (seq_n < 128) begin
            seq_buf[seq_n] = u;
            seq_n++;
        end
    endtask

    task decimal(input int v);
        int d;
        int q;
        bit started;
        d = 10000;
        started = 0;
        v = v & 16'hFFFF;
        while (d > 1) begin
            q = v / d;
            if (q != 0 || started) begin
                seq(dch(q));
                started = 1;
            end
            v = v - q * d;
            d = d / 10;
        end
        seq(dch(v));
    endtask

    task csi_count(input int n, input logic [15:0] fin);
        seq_n = 0;
        seq(tcsgr_pkg::CH_ESC); seq(tcsgr_pkg::CH_LBR); decimal(n); seq(fin);
        for (int i = 0; i < seq_n; i++) emit(seq_buf[i]);
    endtask

    // Colour parameter; base is 3 for foreground, 4 for background, 5 for underline.
    task colour(input logic [31:0] v, input int base);
        case (v[25:24])
            2'd0: begin
                seq(dch(base)); seq(dch(9)); seq(tcsgr_pkg::CH_SEMI);
            end
            2'd1: begin
                if (base == 5) begin
                    seq(dch(5)); seq(dch(8)); seq(tcsgr_pkg::CH_SEMI);
                    seq(dch(5)); seq(tcsgr_pkg::CH_SEMI);
                    decimal(int'(v[3:0])); seq(tcsgr_pkg::CH_SEMI);
                end else if (v[3]) begin
                    if (base == 3) seq(dch(9));
                    else begin
                        seq(dch(1)); seq(dch(0));
                    end
                    seq(dch(int'(v[2:0]))); seq(tcsgr_pkg::CH_SEMI);
                end else begin
                    seq(dch(base)); seq(dch(int'(v[2:0]))); seq(tcsgr_pkg::CH_SEMI);
                end
            end
            2'd2: begin
                seq(dch(base)); seq(dch(8)); seq(tcsgr_pkg::CH_SEMI);
                seq(dch(5)); seq(tcsgr_pkg::CH_SEMI);
                decimal(int'(v[7:0])); seq(tcsgr_pkg::CH_SEMI);
            end
            default: begin
                seq(dch(base)); seq(dch(8)); seq(tcsgr_pkg::CH_SEMI);
                seq(dch(2)); seq(tcsgr_pkg::CH_SEMI);
                decimal(int'(v[23:16])); seq(tcsgr_pkg::CH_SEMI);
                decimal(int'(v[15:8])); seq(tcsgr_pkg::CH_SEMI);
                decimal(int'(v[7:0])); seq(tcsgr_pkg::CH_SEMI);
            end
        endcase
    endtask

    task flag(input logic [31:0] v, input logic [31:0] d, input int bitpos,
              input int on_code, input int off_code);
        if (d[bitpos]) begin
            if (v[bitpos]) begin
                seq(dch(on_code)); seq(tcsgr_pkg::CH_SEMI);
            end else begin
                seq(dch(2)); seq(dch(off_code)); seq(tcsgr_pkg::CH_SEMI);
            end
        end
    endtask

    task sgr(input logic [31:0] fg, input logic [31:0] bg, input logic [31:0] ul);
        logic [31:0] dfg, dbg, dul;
        dfg = fg ^ st_fg;
        dbg = bg ^ st_bg;
        dul = ul ^ st_ul;
        seq_n = 0;
        seq(tcsgr_pkg::CH_ESC); seq(tcsgr_pkg::CH_LBR);
        if (fg == 32'h0 && bg == 32'h0) begin
            seq(tcsgr_pkg::CH_SEMI);
        end else begin
            flag(fg, dfg, 26, 7, 7);
            flag(fg, dfg, 27, 1, 2);
            flag(fg, dfg, 29, 5, 5);
            flag(fg, dfg, 30, 8, 8);
            flag(fg, dfg, 31, 9, 9);
            if ((dfg & tcsgr_pkg::COLOR_BITS) != 0) colour(fg, 3);
            flag(bg, dbg, 26, 3, 3);
            flag(bg, dbg, 27, 2, 2);
            if ((dbg & tcsgr_pkg::COLOR_BITS) != 0) colour(bg, 4);
            if ((bg & tcsgr_pkg::HAS_EXT) != 0) begin
                if ((dul & tcsgr_pkg::UL_STYLE) != 0) begin
                    seq(dch(4)); seq(tcsgr_pkg::CH_COLON);
                    seq(dch(int'(ul[28:26]))); seq(tcsgr_pkg::CH_SEMI);
                end
                if ((dul & tcsgr_pkg::COLOR_BITS) != 0) colour(ul, 5);
            end
        end
        if (seq_n > 2) begin
            seq_buf[seq_n - 1] = tcsgr_pkg::CH_M;
            for (int i = 0; i < seq_n; i++) emit(seq_buf[i]);
        end
    endtask

    task flush_jump();
        if (st_jump != 0) begin
            if (st_bg != st_line_bg) csi_count(st_jump, tcsgr_pkg::CH_X);
            csi_count(st_jump, tcsgr_pkg::CH_C);
            st_jump = 0;
        end
    endtask

    task start_line();
        st_line_bg = st_bg;
        st_jump    = 0;
        st_skip    = 0;
        st_col     = 0;
    endtask

    task encode_cell(input t_cell c);
        logic [31:0] bg;
        logic [20:0] cp;
        int          w;
        bg = c.bg & ~tcsgr_pkg::HAS_EXT;
        if (c.fg != st_fg || bg != st_bg || c.ul != st_ul) begin
            flush_jump();
            sgr(c.fg, c.bg, c.ul);
            st_fg = c.fg;
            st_bg = bg;
            st_ul = c.ul;
        end
        if (c.link != st_link) begin
            if (st_link != 0) begin
                emit(tcsgr_pkg::CH_ESC); emit(tcsgr_pkg::CH_RBR); emit(dch(8));
                emit(tcsgr_pkg::CH_SEMI); emit(tcsgr_pkg::CH_SEMI);
                emit(tcsgr_pkg::CH_BEL);
            end
            if ((c.bg & tcsgr_pkg::HAS_EXT) != 0 && c.link != 0) begin
                flush_units();
                put_res(tcsgr_pkg::KIND_LINK, 0, c.link, 0);
                st_link = c.link;
            end else begin
                st_link = 32'h0;
            end
        end
        if (c.content[21:0] != 0) begin
            flush_jump();
            if (c.content[21]) begin
                flush_units();
                put_res(tcsgr_pkg::KIND_COMB, 0, 32'h0, st_col);
            end else begin
                cp = c.content[20:0];
                if (cp > 21'hFFFF) begin
                    cp = cp - 21'h10000;
                    emit(16'(cp >> 10) + tcsgr_pkg::SURR_HI);
                    emit(16'(cp[9:0]) + tcsgr_pkg::SURR_LO);
                end else begin
                    emit(cp[15:0]);
                end
            end
        end else if (st_jump < int'(tcsgr_pkg::JUMP_MAX)) begin
            st_jump++;
        end
        w = int'(c.content[23:22]);
        st_skip = (w > 1) ? w - 1 : 0;
    endtask

    // Works out the results that one accepted request causes and queues them.
    task encode_request(input t_cell c);
        step_res.delete();
        unit_n = 0;
        if (c.req_type == REQ_LOAD) begin
            st_fg   = c.fg;
            st_bg   = c.bg;
            st_ul   = c.ul;
            st_link = c.link;
            start_line();
        end else begin
            if (c.first) start_line();
            if (st_skip != 0) st_skip--;
            else encode_cell(c);
            if (c.last) begin
                if (st_jump != 0 && st_bg != st_line_bg) csi_count(st_jump, tcsgr_pkg::CH_X);
                start_line();
            end else if (st_col < COL_LAST) begin
                st_col++;
            end
            flush_units();
            if (step_res.size() > 0) step_res[step_res.size() - 1].run_end = 1'b1;
        end
    endtask

    function t_cell mk(input bit rt, input logic [23:0] ct, input logic [31:0] fg,
                       input logic [31:0] bg, input logic [31:0] ul, input logic [31:0] lk,
                       input bit first, input bit last);
        t_cell c;
        c.req_type = rt; c.content = ct; c.fg = fg; c.bg = bg; c.ul = ul; c.link = lk;
        c.first = first; c.last = last;
        return c;
    endfunction

    function t_res text_res(input logic [15:0] a, input logic [15:0] b, input int cnt);
        t_res r;
        r.kind = tcsgr_pkg::KIND_TEXT; r.u0 = a; r.u1 = b; r.u2 = 16'h0; r.u3 = 16'h0;
        r.cnt = 3'(cnt); r.link = 32'h0; r.col = 10'h0; r.run_end = 1'b1;
        return r;
    endfunction

    task add_row(input t_cell c);
        t_row row;
        row.c = c;
        row.typed = 0;
        rows.push_back(row);
    endtask

    task add_typed(input t_cell c, input t_res r);
        t_row row;
        row.c = c;
        row.typed = 1;
        row.r = r;
        rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task send(input t_cell c, input bit typed, input t_res r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            cell_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.req_type   <= c.req_type;
        cell_if.content    <= c.content;
        cell_if.fg_attr    <= c.fg;
        cell_if.bg_attr    <= c.bg;
        cell_if.ul_ext     <= c.ul;
        cell_if.link_id    <= c.link;
        cell_if.first_cell <= c.first;
        cell_if.last_cell  <= c.last;
        do @(posedge i_clk); while (!cell_if.ready);
        encode_request(c);
        if (typed) sgr_expected.push_back(r);
        else foreach (step_res[i]) sgr_expected.push_back(step_res[i]);
        @(negedge i_clk);
    endtask

    // Attributes of the random lines; they change now and then, as on a real screen.
    logic [31:0] cur_fg, cur_bg, cur_ul, cur_link;

    function logic [31:0] rand_colour();
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'h0100_0000 | $urandom_range(0, 15);
            2: return 32'h0200_0000 | $urandom_range(0, 255);
            default: return 32'h0300_0000 | ($urandom & 32'h00FF_FFFF);
        endcase
    endfunction

    function t_cell rand_cell(input bit first, input bit last);
        t_cell c;
        int pick;
        if ($urandom_range(0, 99) < 20) begin
            cur_fg = rand_colour() | ($urandom_range(0, 1) ? ($urandom & 32'hFC00_0000) : 0);
            cur_bg = rand_colour() | ($urandom & 32'h1C00_0000);
            cur_ul = rand_colour() | ($urandom & tcsgr_pkg::UL_STYLE);
            if ($urandom_range(0, 9) == 0) begin
                cur_fg = 32'h0;
                cur_bg = 32'h0;
            end
        end
        if ($urandom_range(0, 99) < 15) cur_link = $urandom_range(0, 1) ? $urandom_range(1, 9) : 0;
        pick = $urandom_range(0, 99);
        if (pick < 30) c.content = 24'h0;
        else if (pick < 70) c.content = 24'($urandom_range(32'h20, 32'h7E));
        else if (pick < 80) c.content = 24'($urandom_range(32'h80, 32'hFFFF));
        else if (pick < 88) c.content = 24'($urandom_range(32'h10000, 32'h10FFFF));
        else if (pick < 92) c.content = 24'h20_0000 | 24'($urandom_range(1, 32'hFFFF));
        else if (pick < 98)
            c.content = {2'($urandom_range(2, 3)), 22'($urandom_range(32'h4E00, 32'h9FFF))};
        else c.content = 24'($urandom);
        c.req_type = REQ_CELL;
        c.fg = cur_fg; c.bg = cur_bg; c.ul = cur_ul; c.link = cur_link;
        c.first = first; c.last = last;
        return c;
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("terminal_cell_to_ansi_sgr_encoder regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_go = 0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (sgr_expected.size() == 0) begin
                report("unexpected result kind", 32'h0, 32'(res_if.kind));
            end else begin
                e = sgr_expected.pop_front();
                if (res_if.kind !== e.kind) report("kind", 32'(e.kind), 32'(res_if.kind));
                if (res_if.unit0 !== e.u0) report("unit0", 32'(e.u0), 32'(res_if.unit0));
                if (res_if.unit1 !== e.u1) report("unit1", 32'(e.u1), 32'(res_if.unit1));
                if (res_if.unit2 !== e.u2) report("unit2", 32'(e.u2), 32'(res_if.unit2));
                if (res_if.unit3 !== e.u3) report("unit3", 32'(e.u3), 32'(res_if.unit3));
                if (res_if.unit_count !== e.cnt)
                    report("unit_count", 32'(e.cnt), 32'(res_if.unit_count));
                if (res_if.marker_link !== e.link)
                    report("marker_link", e.link, res_if.marker_link);
                if (res_if.marker_column !== e.col)
                    report("marker_column", 32'(e.col), 32'(res_if.marker_column));
                if (res_if.run_end !== e.run_end)
                    report("run_end", 32'(e.run_end), 32'(res_if.run_end));
            end
        end
    end

    initial begin
        t_res none;
        int   line_len;
        int   sent;
        bit   hold_done;
        bit   pause_done;
        errors = 0; cycles = 0; hold_go = 0; hold_cnt = 0;
        hold_done = 0; pause_done = 0;
        tx_idle_pct = 24; rx_idle_pct = 69;
        st_fg = 0; st_bg = 0; st_ul = 0; st_link = 0;
        st_line_bg = 0; st_jump = 0; st_skip = 0; st_col = 0;
        cur_fg = 0; cur_bg = 0; cur_ul = 0; cur_link = 0;
        none = text_res(16'h0, 16'h0, 0);
        i_rst_n = 1'b0;
        cell_if.valid = 1'b0; cell_if.req_type = REQ_CELL; cell_if.content = '0;
        cell_if.fg_attr = '0; cell_if.bg_attr = '0; cell_if.ul_ext = '0;
        cell_if.link_id = '0; cell_if.first_cell = 1'b0; cell_if.last_cell = 1'b0;
        res_if.ready = 1'b0;

        // Directed rows: plain text, jumps, colour modes, flags, links, wide cells,
        // combined cells, loads, the attribute reset and all-ones fields.
        add_typed(mk(REQ_CELL, 24'h41, 0, 0, 0, 0, 1, 0), text_res(16'h41, 16'h0, 1));
        add_row(mk(REQ_CELL, 24'h0, 0, 0, 0, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h0, 0, 0, 0, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h42, 32'h0100_0009, 0, 0, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h1F600, 32'h0F12_3456, 0, 0, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h804E2D, 32'h0F12_3456, 32'h1E00_00C8, 32'h0D00_000C, 5, 0, 0));
        add_row(mk(REQ_CELL, 24'h78, 0, 0, 0, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h200041, 32'h0F12_3456, 32'h1E00_00C8, 32'h0D00_000C, 0, 0, 0));
        add_row(mk(REQ_LOAD, 24'h0, 0, 32'h0100_0002, 0, 7, 0, 0));
        add_row(mk(REQ_CELL, 24'h0, 0, 32'h0100_0004, 0, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h0, 0, 32'h0100_0004, 0, 0, 0, 1));
        add_row(mk(REQ_CELL, 24'h7A, 0, 0, 0, 0, 1, 0));
        add_row(mk(REQ_CELL, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 1, 0));
        add_row(mk(REQ_CELL, 24'hC00041, 0, 0, 0, 0, 1, 0));
        add_row(mk(REQ_CELL, 24'h41, 0, 0, 0, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h41, 0, 0, 0, 0, 0, 1));
        add_row(mk(REQ_CELL, 24'h1FFFFF, 32'h0100_0003, 0, 0, 0, 1, 0));
        add_row(mk(REQ_CELL, 24'h0, 32'h1100_0003, 0, 0, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h43, 32'h1100_0003, 32'h1000_0000, 32'h0400_0000, 0, 0, 0));
        add_row(mk(REQ_CELL, 24'h44, 32'h1100_0003, 32'h1000_0000, 32'h0300_0000, 3, 0, 1));
        add_row(mk(REQ_LOAD, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 1, 1));
        add_row(mk(REQ_CELL, 24'h0, 0, 0, 0, 0, 1, 0));
        add_row(mk(REQ_CELL, 24'h0, 0, 0, 0, 0, 0, 1));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].r);

        // Random lines, mostly well formed, with some loads and raw noise mixed in.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent >= RAND_ITEMS / 3 && sent < 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 69; rx_idle_pct = 24;
            end else if (sent >= 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            // The receiver holds off while requests keep coming, so the queue fills.
            if (sent >= 100 && !hold_done) begin
                hold_go = 1;
                hold_done = 1;
            end
            // The sender drains the block before going on.
            if (sent >= 200 && !pause_done) begin
                cell_if.valid <= 1'b0;
                while (sgr_expected.size() != 0) @(negedge i_clk);
                pause_done = 1;
            end
            line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int k = 0; k < line_len; k++) begin
                if ($urandom_range(0, 99) < 5)
                    send(mk(1'($urandom), 24'($urandom), $urandom, $urandom, $urandom, $urandom,
                            1'($urandom), 1'($urandom)), 0, none);
                else if ($urandom_range(0, 99) < 2)
                    send(mk(REQ_LOAD, 0, rand_colour(), rand_colour(), rand_colour(),
                            $urandom_range(0, 3), 0, 0), 0, none);
                else
                    send(rand_cell(k == 0, k == line_len - 1), 0, none);
                sent++;
            end
        end

        // A long run of empty cells, closed by a combined cell.
        send(mk(REQ_CELL, 24'h0, cur_fg, cur_bg, cur_ul, cur_link, 1, 0), 0, none);
        for (int k = 0; k < 30; k++)
            send(mk(REQ_CELL, 24'h0, cur_fg, cur_bg, cur_ul, cur_link, 0, 0), 0, none);
        send(mk(REQ_CELL, 24'h200041, cur_fg, cur_bg, cur_ul, cur_link, 0, 1), 0, none);
        cell_if.valid <= 1'b0;

        while (sgr_expected.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sgr_expected.size() != 0) report("results left over", 0, sgr_expected.size());
        if (errors == 0) begin
            $display("terminal_cell_to_ansi_sgr_encoder regression: pass");
        end else begin
            $display("terminal_cell_to_ansi_sgr_encoder regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
sv/tcsgr_pkg.sv
sv/tcsgr_if.sv
sv/tcsgr_front.sv
sv/tcsgr_queue.sv
sv/tcsgr_back.sv
sv/terminal_cell_to_ansi_sgr_encoder.sv
sv/tcsgr_checker.sv
tb/tb_terminal_cell_to_ansi_sgr_encoder.sv
